>>> design/uniform_grid_rect_index_unit_assert.svh
// assertion macros for the uniform grid rectangle index
`ifndef UNIFORM_GRID_RECT_INDEX_UNIT_ASSERT_SVH
`define UNIFORM_GRID_RECT_INDEX_UNIT_ASSERT_SVH

// checked outside reset
`define UGRI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every rising edge, reset included
`define UGRI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> design/ugri_pkg.sv
// shared types, codes and constants of the uniform grid rectangle index
package ugri_pkg;

    localparam int MAX_RECTS_DEF   = 64;
    localparam int MAX_COLUMNS_DEF = 16;
    localparam int MAX_ROWS_DEF    = 16;

    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;
    localparam int COORD_W  = 24;
    localparam int SIZE_W   = 23;
    localparam int IDX_W    = 6;
    localparam int DIM_W    = 7;
    localparam int CO_W     = 6;
    localparam int DIV_W    = 25;
    localparam int DIV_CNT_W = 5;
    localparam int EXT_W    = 26;

    localparam logic [SIZE_W-1:0] CELL_MIN = 23'd256;

    localparam logic [1:0] KIND_BEGIN  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDS_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDS_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDS_W  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDS_H  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_W    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_H    = 3'd5;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [SIZE_W-1:0]         rect_width;
        logic [SIZE_W-1:0]         rect_height;
        logic [SIZE_W-1:0]         radius;
    } in_word_t;

    typedef struct packed {
        logic [IDX_W-1:0] rect_index;
        logic             found;
        logic             overflow;
        logic             last;
    } out_word_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [SIZE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_resp_t;

endpackage

>>> design/ugri_div.sv
// bit-serial restoring divider for cell coordinates and grid size
module ugri_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  ugri_pkg::div_req_t  req,
    output ugri_pkg::div_resp_t resp
);
    import ugri_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     acc_reg;
    logic [SIZE_W-1:0]    rem_reg;
    logic [SIZE_W-1:0]    divisor_reg;
    logic [SIZE_W:0]      trial;
    logic [SIZE_W:0]      diff;
    logic                 take;

    assign trial = {rem_reg, acc_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign take  = trial >= {1'b0, divisor_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            cnt_reg     <= '0;
            acc_reg     <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            acc_reg <= {acc_reg[DIV_W-2:0], take};
            rem_reg <= take ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
        end
    end

    assign resp.busy     = busy_reg;
    assign resp.done     = done_reg;
    assign resp.quotient = acc_reg;

endmodule

>>> design/ugri_cell_mem.sv
// cell membership bitmap memory, one write and one registered read port
module ugri_cell_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 64
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/uniform_grid_rect_index_unit.sv
// uniform grid broad-phase index: top level with sequencer and result register
// One word is processed at a time. A begin word sweeps the whole cell memory
// (MAX_COLUMNS*MAX_ROWS cells) and then runs two divisions for the grid size
// on the serial divider. An insert or query runs up to four such divisions for
// the covered cell range, then reads each covered cell in two steps (read,
// then write back or accumulate); a query then scans its hit bitmap one index
// a cycle while the result register is free. Results leave through a register
// that holds while the next word is taken.
`include "uniform_grid_rect_index_unit_assert.svh"

module uniform_grid_rect_index_unit #(
    parameter int MAX_RECTS   = ugri_pkg::MAX_RECTS_DEF,
    parameter int MAX_COLUMNS = ugri_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = ugri_pkg::MAX_ROWS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [ugri_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ugri_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ugri_pkg::in_word_t                 s_word,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ugri_pkg::out_word_t                m_word
);
    import ugri_pkg::*;

    localparam int NUM_CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int AW        = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int RW        = MAX_RECTS;
    localparam int CNT_W     = $clog2(MAX_RECTS + 1);
    localparam int SCAN_W    = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int PROD_W    = CO_W + DIM_W;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CLEAR    = 4'd1;
    localparam logic [3:0] ST_DIV_GO   = 4'd2;
    localparam logic [3:0] ST_DIV_WAIT = 4'd3;
    localparam logic [3:0] ST_WALK_RD  = 4'd4;
    localparam logic [3:0] ST_WALK_WR  = 4'd5;
    localparam logic [3:0] ST_EMIT     = 4'd6;
    localparam logic [3:0] ST_RESULT   = 4'd7;

    // configuration registers
    logic [CFG_W-1:0]  bx_reg, by_reg;
    logic [SIZE_W-1:0] bw_reg, bh_reg, cwcfg_reg, chcfg_reg;

    // latched grid
    logic signed [COORD_W-1:0] org_x_reg, org_y_reg;
    logic [SIZE_W-1:0]         cw_reg, ch_reg;
    logic [DIM_W-1:0]          gcols_reg, grows_reg;
    logic                      built_reg;
    logic [CNT_W-1:0]          rect_count_reg;

    logic [3:0]       state_reg;
    in_word_t         item_reg;
    logic [1:0]       job_reg;
    logic [AW-1:0]    clear_reg;
    logic [CO_W-1:0]  c0_reg, c1_reg, r0_reg, r1_reg, cur_c_reg, cur_r_reg;
    logic [RW-1:0]    acc_reg;
    logic [SCAN_W-1:0] scan_reg;
    out_word_t        res_reg;
    logic             m_valid_reg;
    out_word_t        m_word_reg;

    div_req_t  div_req;
    div_resp_t div_resp;

    logic                       is_begin, is_insert, last_job, skip, out_free, walk_end;
    logic                       emit_hit, res_load, ins_full, walk_in_range;
    logic signed [EXT_W-1:0]    lo_x, hi_x, lo_y, hi_y, coord, origin, delta;
    logic [SIZE_W-1:0]          size;
    logic [DIM_W-1:0]           count;
    logic [DIM_W-1:0]           limit;
    logic [CO_W-1:0]            axis_q;
    logic [DIM_W-1:0]           grid_q;
    logic [PROD_W-1:0]          prod;
    logic [AW-1:0]              cell_addr;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [RW-1:0]              mem_wdata, mem_rdata, ins_bit, acc_or, acc_clr;
    logic [SIZE_W-1:0]          cw_clamp, ch_clamp;

    assign is_begin  = item_reg.kind == KIND_BEGIN;
    assign is_insert = item_reg.kind == KIND_INSERT;
    assign last_job  = is_begin ? (job_reg == 2'd1) : (job_reg == 2'd3);
    assign out_free  = !m_valid_reg || m_ready;
    assign cw_clamp  = (cwcfg_reg < CELL_MIN) ? CELL_MIN : cwcfg_reg;
    assign ch_clamp  = (chcfg_reg < CELL_MIN) ? CELL_MIN : chcfg_reg;
    assign ins_full  = built_reg && (rect_count_reg >= CNT_W'(MAX_RECTS));

    // span ends per axis
    always_comb begin
        if (is_insert) begin
            lo_x = EXT_W'(item_reg.pos_x);
            hi_x = EXT_W'(item_reg.pos_x) + EXT_W'(item_reg.rect_width);
            lo_y = EXT_W'(item_reg.pos_y);
            hi_y = EXT_W'(item_reg.pos_y) + EXT_W'(item_reg.rect_height);
        end else begin
            lo_x = EXT_W'(item_reg.pos_x) - EXT_W'(item_reg.radius);
            hi_x = EXT_W'(item_reg.pos_x) + EXT_W'(item_reg.radius);
            lo_y = EXT_W'(item_reg.pos_y) - EXT_W'(item_reg.radius);
            hi_y = EXT_W'(item_reg.pos_y) + EXT_W'(item_reg.radius);
        end
    end

    always_comb begin
        case (job_reg)
            2'd0: begin
                coord = lo_x; origin = EXT_W'(org_x_reg); size = cw_reg; count = gcols_reg;
            end
            2'd1: begin
                coord = hi_x; origin = EXT_W'(org_x_reg); size = cw_reg; count = gcols_reg;
            end
            2'd2: begin
                coord = lo_y; origin = EXT_W'(org_y_reg); size = ch_reg; count = grows_reg;
            end
            default: begin
                coord = hi_y; origin = EXT_W'(org_y_reg); size = ch_reg; count = grows_reg;
            end
        endcase
        delta = coord - origin;
        skip = (count <= DIM_W'(1)) || delta[EXT_W-1];
    end

    // divider request
    always_comb begin
        div_req.start = (state_reg == ST_DIV_GO) && (is_begin || !skip);
        if (is_begin) begin
            if (job_reg == 2'd0) begin
                div_req.dividend = DIV_W'(bw_reg) + DIV_W'(cw_reg) - 1'b1;
                div_req.divisor  = cw_reg;
            end else begin
                div_req.dividend = DIV_W'(bh_reg) + DIV_W'(ch_reg) - 1'b1;
                div_req.divisor  = ch_reg;
            end
        end else begin
            div_req.dividend = delta[DIV_W-1:0];
            div_req.divisor  = size;
        end
    end

    // quotient clamps
    always_comb begin
        limit = (job_reg == 2'd0) ? DIM_W'(MAX_COLUMNS) : DIM_W'(MAX_ROWS);
        if (div_resp.quotient > DIV_W'(count - 1'b1)) begin
            axis_q = CO_W'(count - 1'b1);
        end else begin
            axis_q = CO_W'(div_resp.quotient);
        end
        if (div_resp.quotient == '0) begin
            grid_q = DIM_W'(1);
        end else if (div_resp.quotient > DIV_W'(limit)) begin
            grid_q = limit;
        end else begin
            grid_q = DIM_W'(div_resp.quotient);
        end
    end

    assign prod      = PROD_W'(cur_r_reg) * PROD_W'(gcols_reg) + PROD_W'(cur_c_reg);
    assign cell_addr = prod[AW-1:0];
    assign ins_bit   = RW'(1) << rect_count_reg;
    assign acc_or    = acc_reg | mem_rdata;
    assign acc_clr   = acc_reg & ~(RW'(1) << scan_reg);
    assign walk_end  = (cur_c_reg == c1_reg) && (cur_r_reg == r1_reg);
    assign emit_hit  = (state_reg == ST_EMIT) && out_free && acc_reg[scan_reg];
    assign res_load  = (state_reg == ST_RESULT) && out_free;

    assign mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WALK_WR && is_insert);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clear_reg : cell_addr;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : (mem_rdata | ins_bit);

    ugri_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .resp    (div_resp)
    );

    ugri_cell_mem #(
        .DEPTH (NUM_CELLS),
        .AW    (AW),
        .DW    (RW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (cell_addr),
        .rdata (mem_rdata)
    );

    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bx_reg    <= '0;
            by_reg    <= '0;
            bw_reg    <= '0;
            bh_reg    <= '0;
            cwcfg_reg <= CELL_MIN;
            chcfg_reg <= CELL_MIN;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_BOUNDS_X: bx_reg    <= cfg_data;
                CFG_BOUNDS_Y: by_reg    <= cfg_data;
                CFG_BOUNDS_W: bw_reg    <= cfg_data[SIZE_W-1:0];
                CFG_BOUNDS_H: bh_reg    <= cfg_data[SIZE_W-1:0];
                CFG_CELL_W:   cwcfg_reg <= cfg_data[SIZE_W-1:0];
                CFG_CELL_H:   chcfg_reg <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            built_reg      <= 1'b0;
            rect_count_reg <= '0;
            gcols_reg      <= '0;
            grows_reg      <= '0;
            org_x_reg      <= '0;
            org_y_reg      <= '0;
            cw_reg         <= CELL_MIN;
            ch_reg         <= CELL_MIN;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg <= s_word;
                        job_reg  <= 2'd0;
                        acc_reg  <= '0;
                        res_reg  <= '{rect_index: '0, found: 1'b0,
                                      overflow: (s_word.kind == KIND_INSERT) && ins_full,
                                      last: 1'b1};
                        case (s_word.kind)
                            KIND_BEGIN: begin
                                org_x_reg      <= signed'(bx_reg);
                                org_y_reg      <= signed'(by_reg);
                                cw_reg         <= cw_clamp;
                                ch_reg         <= ch_clamp;
                                rect_count_reg <= '0;
                                clear_reg      <= '0;
                                state_reg      <= ST_CLEAR;
                            end
                            KIND_INSERT: begin
                                state_reg <= (built_reg && !ins_full) ? ST_DIV_GO : ST_RESULT;
                            end
                            KIND_QUERY: begin
                                state_reg <= (built_reg && rect_count_reg != '0) ?
                                             ST_DIV_GO : ST_RESULT;
                            end
                            default: state_reg <= ST_RESULT;
                        endcase
                    end
                end
                ST_CLEAR: begin
                    clear_reg <= clear_reg + 1'b1;
                    if (clear_reg == AW'(NUM_CELLS - 1)) begin
                        state_reg <= ST_DIV_GO;
                    end
                end
                ST_DIV_GO: begin
                    if (!is_begin && skip) begin
                        case (job_reg)
                            2'd0:    c0_reg <= '0;
                            2'd1:    c1_reg <= '0;
                            2'd2:    r0_reg <= '0;
                            default: r1_reg <= '0;
                        endcase
                        job_reg <= job_reg + 1'b1;
                        if (last_job) begin
                            cur_c_reg <= c0_reg;
                            cur_r_reg <= r0_reg;
                            state_reg <= ST_WALK_RD;
                        end
                    end else begin
                        state_reg <= ST_DIV_WAIT;
                    end
                end
                ST_DIV_WAIT: begin
                    if (div_resp.done) begin
                        job_reg <= job_reg + 1'b1;
                        if (is_begin) begin
                            if (job_reg == 2'd0) begin
                                gcols_reg <= grid_q;
                                state_reg <= ST_DIV_GO;
                            end else begin
                                grows_reg <= grid_q;
                                built_reg <= 1'b1;
                                state_reg <= ST_RESULT;
                            end
                        end else begin
                            case (job_reg)
                                2'd0:    c0_reg <= axis_q;
                                2'd1:    c1_reg <= axis_q;
                                2'd2:    r0_reg <= axis_q;
                                default: r1_reg <= axis_q;
                            endcase
                            if (last_job) begin
                                cur_c_reg <= c0_reg;
                                cur_r_reg <= r0_reg;
                                state_reg <= ST_WALK_RD;
                            end else begin
                                state_reg <= ST_DIV_GO;
                            end
                        end
                    end
                end
                ST_WALK_RD: begin
                    state_reg <= ST_WALK_WR;
                end
                ST_WALK_WR: begin
                    acc_reg <= acc_or;
                    if (cur_c_reg == c1_reg) begin
                        cur_c_reg <= c0_reg;
                        cur_r_reg <= cur_r_reg + 1'b1;
                    end else begin
                        cur_c_reg <= cur_c_reg + 1'b1;
                    end
                    if (walk_end) begin
                        scan_reg <= '0;
                        if (is_insert) begin
                            res_reg <= '{rect_index: IDX_W'(rect_count_reg), found: 1'b1,
                                         overflow: 1'b0, last: 1'b1};
                            rect_count_reg <= rect_count_reg + 1'b1;
                            state_reg      <= ST_RESULT;
                        end else if (acc_or == '0) begin
                            state_reg <= ST_RESULT;
                        end else begin
                            state_reg <= ST_EMIT;
                        end
                    end else begin
                        state_reg <= ST_WALK_RD;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                    if (emit_hit) begin
                        acc_reg <= acc_clr;
                        if (acc_clr == '0) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_RESULT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_hit || res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_hit) begin
            m_word_reg <= '{rect_index: IDX_W'(scan_reg), found: 1'b1,
                            overflow: 1'b0, last: acc_clr == '0};
        end else if (res_load) begin
            m_word_reg <= res_reg;
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    assign walk_in_range = (cur_c_reg >= c0_reg) && (cur_c_reg <= c1_reg) &&
                           (cur_r_reg <= r1_reg);

    `UGRI_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (state_reg == ST_IDLE && !m_valid_reg), "reset did not idle")
    `UGRI_ASSERT(a_count_bound, rect_count_reg <= CNT_W'(MAX_RECTS), "rect count past capacity")
    `UGRI_ASSERT(a_div_idle_start, div_req.start |-> !div_resp.busy, "divider restarted while busy")
    `UGRI_ASSERT(a_walk_range, (state_reg == ST_WALK_RD) |-> walk_in_range, "walk left its cell range")
    `UGRI_ASSERT(a_emit_nonempty, (state_reg == ST_EMIT) |-> (acc_reg != '0), "scan with empty bitmap")

endmodule

>>> bench/tb_uniform_grid_rect_index_unit.sv
// testbench for the uniform grid rectangle index: directed table, capacity burst, random phases
module tb_uniform_grid_rect_index_unit;
    import ugri_pkg::*;

    localparam longint RUN_LIMIT = 3000000;

    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t e;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_word_t s_word = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_word_t m_word;

    uniform_grid_rect_index_unit dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_valid(s_valid), .s_ready(s_ready), .s_word(s_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_word(m_word)
    );

    always #10 aclk = ~aclk;

    // shadow registers and grid state
    logic [23:0] sh_bx, sh_by;
    logic [22:0] sh_bw, sh_bh, sh_cw, sh_ch;
    logic [63:0] cell_bits [256];
    int     rects_held, grid_cols, grid_rws;
    bit     grid_built;
    longint org_x, org_y, cell_w, cell_h;

    out_word_t pending_results[$];
    int errors = 0;
    int items_sent = 0;
    int words_seen = 0;
    int words_paced = 0;
    int queries_hit = 0;
    bit no_idle = 1'b0;
    int rx_stall = 0;
    longint cycles = 0;

    function automatic int grid_span(longint extent, longint cell_sz, int lim);
        longint n;
        n = (extent + cell_sz - 1) / cell_sz;
        if (n < 1) n = 1;
        if (n > lim) n = lim;
        return int'(n);
    endfunction

    function automatic int cell_of(longint c, longint origin, longint size, int count);
        longint d;
        longint q;
        if (count <= 1) return 0;
        d = c - origin;
        if (d < 0) return 0;
        q = d / size;
        if (q > count - 1) q = count - 1;
        return int'(q);
    endfunction

    function automatic out_word_t ow(int idx, bit f, bit o, bit l);
        out_word_t r;
        r.rect_index = idx[IDX_W-1:0];
        r.found = f;
        r.overflow = o;
        r.last = l;
        return r;
    endfunction

    function automatic in_word_t mk(logic [1:0] k, longint x, longint y, longint rw,
                                    longint rh, longint rad);
        in_word_t w;
        w.kind = k;
        w.pos_x = x[23:0];
        w.pos_y = y[23:0];
        w.rect_width = rw[22:0];
        w.rect_height = rh[22:0];
        w.radius = rad[22:0];
        return w;
    endfunction

    task automatic reset_grid_model();
        for (int i = 0; i < 256; i++) cell_bits[i] = '0;
        sh_bx = '0; sh_by = '0; sh_bw = '0; sh_bh = '0;
        sh_cw = CELL_MIN; sh_ch = CELL_MIN;
        rects_held = 0; grid_cols = 0; grid_rws = 0; grid_built = 0;
        org_x = 0; org_y = 0; cell_w = 256; cell_h = 256;
    endtask

    task automatic grid_index_step(in_word_t w, ref out_word_t res[$]);
        longint px, py, rw, rh, rad;
        int c0, c1, r0, r1, top;
        logic [63:0] acc;
        px = longint'($signed(w.pos_x));
        py = longint'($signed(w.pos_y));
        rw = longint'(w.rect_width);
        rh = longint'(w.rect_height);
        rad = longint'(w.radius);
        res = {};
        case (w.kind)
            KIND_BEGIN: begin
                for (int i = 0; i < 256; i++) cell_bits[i] = '0;
                rects_held = 0;
                org_x = longint'($signed(sh_bx));
                org_y = longint'($signed(sh_by));
                cell_w = (sh_cw < 256) ? 256 : longint'(sh_cw);
                cell_h = (sh_ch < 256) ? 256 : longint'(sh_ch);
                grid_cols = grid_span(longint'(sh_bw), cell_w, MAX_COLUMNS_DEF);
                grid_rws = grid_span(longint'(sh_bh), cell_h, MAX_ROWS_DEF);
                grid_built = 1;
                res = {res, ow(0, 0, 0, 1)};
            end
            KIND_INSERT: begin
                if (!grid_built) res = {res, ow(0, 0, 0, 1)};
                else if (rects_held >= MAX_RECTS_DEF) res = {res, ow(0, 0, 1, 1)};
                else begin
                    c0 = cell_of(px, org_x, cell_w, grid_cols);
                    c1 = cell_of(px + rw, org_x, cell_w, grid_cols);
                    r0 = cell_of(py, org_y, cell_h, grid_rws);
                    r1 = cell_of(py + rh, org_y, cell_h, grid_rws);
                    for (int r = r0; r <= r1; r++)
                        for (int c = c0; c <= c1; c++)
                            if (r * grid_cols + c < 256)
                                cell_bits[r * grid_cols + c][rects_held] = 1'b1;
                    res = {res, ow(rects_held, 1, 0, 1)};
                    rects_held++;
                end
            end
            KIND_QUERY: begin
                acc = '0;
                if (grid_built && rects_held != 0) begin
                    c0 = cell_of(px - rad, org_x, cell_w, grid_cols);
                    c1 = cell_of(px + rad, org_x, cell_w, grid_cols);
                    r0 = cell_of(py - rad, org_y, cell_h, grid_rws);
                    r1 = cell_of(py + rad, org_y, cell_h, grid_rws);
                    for (int r = r0; r <= r1; r++)
                        for (int c = c0; c <= c1; c++)
                            if (r * grid_cols + c < 256) acc |= cell_bits[r * grid_cols + c];
                end
                if (acc == '0) res = {res, ow(0, 0, 0, 1)};
                else begin
                    top = 0;
                    for (int i = 0; i < 64; i++) if (acc[i]) top = i;
                    for (int i = 0; i < 64; i++)
                        if (acc[i]) res = {res, ow(i, 1, 0, i == top)};
                    queries_hit++;
                end
            end
            default: res = {res, ow(0, 0, 0, 1)};
        endcase
    endtask

    // sender: called and returns at a falling edge
    task automatic send_word(in_word_t w, bit typed, out_word_t e);
        int gap;
        out_word_t res[$];
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word <= w;
        do @(posedge aclk); while (!s_ready);
        grid_index_step(w, res);
        if (typed) res = '{e};
        foreach (res[i]) pending_results = {pending_results, res[i]};
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[23:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        case (idx)
            CFG_BOUNDS_X: sh_bx = val[23:0];
            CFG_BOUNDS_Y: sh_by = val[23:0];
            CFG_BOUNDS_W: sh_bw = val[22:0];
            CFG_BOUNDS_H: sh_bh = val[22:0];
            CFG_CELL_W:   sh_cw = val[22:0];
            CFG_CELL_H:   sh_ch = val[22:0];
            default: ;
        endcase
    endtask

    task automatic write_grid(longint bx, longint by, longint bw, longint bh,
                              longint cw, longint ch);
        write_reg(CFG_BOUNDS_X, bx);
        write_reg(CFG_BOUNDS_Y, by);
        write_reg(CFG_BOUNDS_W, bw);
        write_reg(CFG_BOUNDS_H, bh);
        write_reg(CFG_CELL_W, cw);
        write_reg(CFG_CELL_H, ch);
    endtask

    function automatic longint near_coord(longint origin, longint extent, longint cell_sz);
        return origin + longint'($urandom_range(0, 2 * 4096)) - 4096 +
               (longint'($urandom) % (extent + 2 * cell_sz + 1));
    endfunction

    function automatic in_word_t random_word();
        int pick;
        longint cw, ch;
        logic [127:0] raw;
        in_word_t w;
        pick = $urandom_range(0, 99);
        cw = (sh_cw < 256) ? 256 : longint'(sh_cw);
        ch = (sh_ch < 256) ? 256 : longint'(sh_ch);
        if (pick < 12) begin
            raw = {$urandom, $urandom, $urandom, $urandom};
            w = raw[$bits(in_word_t)-1:0];
            if (w.kind == 2'd3 && $urandom_range(0, 1)) w.kind = KIND_QUERY;
        end else if (pick < 18) begin
            w = mk(KIND_BEGIN, $urandom, $urandom, 0, 0, 0);
        end else if (pick < 58) begin
            w = mk(KIND_INSERT,
                   near_coord(longint'($signed(sh_bx)), longint'(sh_bw), cw),
                   near_coord(longint'($signed(sh_by)), longint'(sh_bh), ch),
                   $urandom_range(0, 3) == 0 ? $urandom_range(0, 4 * cw) : $urandom_range(0, cw),
                   $urandom_range(0, 3) == 0 ? $urandom_range(0, 4 * ch) : $urandom_range(0, ch),
                   $urandom);
        end else begin
            w = mk(KIND_QUERY,
                   near_coord(longint'($signed(sh_bx)), longint'(sh_bw), cw),
                   near_coord(longint'($signed(sh_by)), longint'(sh_bh), ch),
                   $urandom, $urandom,
                   $urandom_range(0, 7) == 0 ? $urandom_range(0, 4 * cw) : $urandom_range(0, cw));
        end
        return w;
    endfunction

    // result side
    always @(negedge aclk) begin
        if (words_paced != words_seen) begin
            words_paced = words_seen;
            rx_stall = no_idle ? 0 : $urandom_range(0, 19);
        end
        if (rx_stall > 0) begin
            m_ready <= 1'b0;
            rx_stall = rx_stall - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        out_word_t want;
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("tb_uniform_grid_rect_index_unit: errors");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            words_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected word %p", $time, m_word);
            end else begin
                want = pending_results.pop_front();
                if (m_word.rect_index !== want.rect_index)
                    $display("%0t: rect_index expected %0d got %0d", $time,
                             want.rect_index, m_word.rect_index);
                if (m_word.found !== want.found)
                    $display("%0t: found expected %0b got %0b", $time, want.found, m_word.found);
                if (m_word.overflow !== want.overflow)
                    $display("%0t: overflow expected %0b got %0b", $time,
                             want.overflow, m_word.overflow);
                if (m_word.last !== want.last)
                    $display("%0t: last expected %0b got %0b", $time, want.last, m_word.last);
                if (m_word !== want) errors++;
            end
        end
    end

    dir_row_t dir_rows [12];

    initial begin
        reset_grid_model();
        dir_rows[0]  = '{mk(KIND_QUERY, 0, 0, 0, 0, 100), 1, ow(0, 0, 0, 1)};
        dir_rows[1]  = '{mk(KIND_INSERT, 0, 0, 10, 10, 0), 1, ow(0, 0, 0, 1)};
        dir_rows[2]  = '{mk(2'd3, -1, -1, -1, -1, -1), 1, ow(0, 0, 0, 1)};
        dir_rows[3]  = '{mk(KIND_BEGIN, 0, 0, 0, 0, 0), 1, ow(0, 0, 0, 1)};
        dir_rows[4]  = '{mk(KIND_QUERY, 5, 5, 0, 0, 0), 1, ow(0, 0, 0, 1)};
        dir_rows[5]  = '{mk(KIND_INSERT, -8388608, -8388608, 8388607, 8388607, 0), 1,
                         ow(0, 1, 0, 1)};
        dir_rows[6]  = '{mk(KIND_INSERT, 8388607, 8388607, 0, 0, 8388607), 1, ow(1, 1, 0, 1)};
        dir_rows[7]  = '{mk(KIND_QUERY, 0, 0, 0, 0, 0), 0, ow(0, 0, 0, 0)};
        dir_rows[8]  = '{mk(KIND_QUERY, -8388608, 8388607, 0, 0, 8388607), 0, ow(0, 0, 0, 0)};
        dir_rows[9]  = '{mk(KIND_BEGIN, -1, -1, -1, -1, -1), 1, ow(0, 0, 0, 1)};
        dir_rows[10] = '{mk(KIND_INSERT, 0, 0, 0, 0, 0), 1, ow(0, 1, 0, 1)};
        dir_rows[11] = '{mk(KIND_QUERY, 8388607, -8388608, 0, 0, 0), 0, ow(0, 0, 0, 0)};

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].e);
        drain();

        // extremes: largest grid with clamped cells, ignored index write
        write_grid(-8388608, -8388608, 8388607, 8388607, 0, 0);
        write_reg(3'd6, 24'hFFFFFF);
        write_reg(3'd7, 24'h123456);
        send_word(mk(KIND_BEGIN, 0, 0, 0, 0, 0), 0, '0);
        for (int i = 0; i < 65; i++)
            send_word(mk(KIND_INSERT, -8388608 + $urandom_range(0, 4095),
                         -8388608 + $urandom_range(0, 4095), $urandom_range(0, 600),
                         $urandom_range(0, 600), 0), 0, '0);
        send_word(mk(KIND_QUERY, -8388608, -8388608, 0, 0, 8388607), 0, '0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            no_idle = (ph == 2);
            case (ph)
                0: write_grid(8388607, 8388607, 0, 0, 8388607, 8388607);
                1: write_grid(0, 0, 4096, 2048, 255, 300);
                default: write_grid($urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                                    $urandom_range(0, 6000), $urandom_range(0, 6000),
                                    $urandom_range(0, 900), $urandom_range(0, 900));
            endcase
            send_word(mk(KIND_BEGIN, 0, 0, 0, 0, 0), 0, '0);
            for (int i = 0; i < 20; i++) send_word(random_word(), 0, '0);
            drain();
        end
        no_idle = 1'b0;

        $display("covered %0d input words and %0d result words, %0d queries with hits,",
                 items_sent, words_seen, queries_hit);
        $display("over default, saturated, clamped and random grid settings");
        if (errors == 0) begin
            $display("tb_uniform_grid_rect_index_unit: clean");
        end else begin
            $display("tb_uniform_grid_rect_index_unit: errors");
        end
        $finish;
    end

endmodule
